### rtl/core/atan2_poly_approx_assert.svh
// assertion macros shared by the atan2 approximation rtl
`ifndef ATAN2_POLY_APPROX_ASSERT_SVH
`define ATAN2_POLY_APPROX_ASSERT_SVH

// same-cycle implication, checked outside reset
`define A2P_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define A2P_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/atan2pa_pkg.sv
`timescale 1ns / 1ps

package atan2pa_pkg;

    localparam int IN_WIDTH_DEF        = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 13;

    // output angle width is fixed, wider formats wrap
    localparam int ANGLE_W = 16;

    // ratio in Q0.16 with one integer bit so that 1.0 fits
    localparam int QUO_W = 17;

    localparam logic [16:0] Q16_ONE = 17'h10000;
    localparam logic [14:0] COEF_C1 = 15'd21471;
    localparam logic [13:0] COEF_C2 = 14'd10441;
    localparam logic [11:0] COEF_C3 = 12'd3047;

    // pi with 60 fraction bits
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    // octant reflection flags that ride along with each transaction
    typedef struct packed {
        logic swap;
        logic xneg;
        logic yneg;
        logic zero;
    } t_oct_flags;

endpackage

### rtl/core/atan2pa_div.sv
`timescale 1ns / 1ps
`include "atan2_poly_approx_assert.svh"

module atan2pa_div
    import atan2pa_pkg::*;
#(
    parameter int NUM_W = IN_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [NUM_W-1:0] i_num,
    input  logic [NUM_W-1:0] i_den,
    input  t_oct_flags       i_oct,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [QUO_W-1:0] o_quo,
    output t_oct_flags       o_oct
);

    // one quotient bit per stage, msb first
    localparam int STG = QUO_W;

    logic [STG-1:0]   r_v;
    logic [NUM_W-1:0] r_rem [STG];
    logic [NUM_W-1:0] r_den [STG];
    logic [QUO_W-1:0] r_q   [STG];
    t_oct_flags       r_oct [STG];

    logic [NUM_W-1:0] n_rem [STG];
    logic [QUO_W-1:0] n_q   [STG];
    logic [NUM_W:0]   w_shift [STG];
    logic [NUM_W-1:0] w_den   [STG];
    logic [QUO_W-1:0] w_qprev [STG];
    t_oct_flags       w_oct   [STG];
    logic [STG-1:0]   w_ge;
    logic [STG-1:0]   w_adv;
    logic [STG-1:0]   w_vin;

    for (genvar k = 0; k < STG; k++) begin : g_stg
        if (k == 0) begin : g_first
            // numerator never exceeds the denominator, so no shift ahead of the top bit
            assign w_shift[k] = {1'b0, i_num};
            assign w_den[k]   = i_den;
            assign w_qprev[k] = '0;
            assign w_oct[k]   = i_oct;
        end else begin : g_next
            assign w_shift[k] = {r_rem[k-1], 1'b0};
            assign w_den[k]   = r_den[k-1];
            assign w_qprev[k] = r_q[k-1];
            assign w_oct[k]   = r_oct[k-1];
        end
        assign w_ge[k]  = w_shift[k] >= {1'b0, w_den[k]};
        assign n_q[k]   = w_qprev[k] | (QUO_W'(w_ge[k]) << (QUO_W - 1 - k));
        assign n_rem[k] = w_ge[k] ? NUM_W'(w_shift[k] - {1'b0, w_den[k]})
                                  : NUM_W'(w_shift[k]);
    end

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        w_adv[STG-1] = !r_v[STG-1] || i_ready;
        for (int k = STG - 2; k >= 0; k--) begin
            w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    end

    assign w_vin = {r_v[STG-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < STG; k++) begin
                if (w_adv[k]) begin
                    r_v[k] <= w_vin[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < STG; k++) begin
            if (w_adv[k]) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= w_den[k];
                r_q[k]   <= n_q[k];
                r_oct[k] <= w_oct[k];
            end
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_v[STG-1];
    assign o_quo   = r_q[STG-1];
    assign o_oct   = r_oct[STG-1];

    `A2P_ASSERT_NEXT(a_div_enter, i_clk, i_rst_n, i_valid && o_ready, r_v[0],
        "accepted transaction did not enter the divider")

    `A2P_ASSERT_NOW(a_div_quo_max, i_clk, i_rst_n, o_valid && !o_oct.zero,
        o_quo <= Q16_ONE, "ratio above one")

    for (genvar k = 0; k < STG; k++) begin : g_chk
        `A2P_ASSERT_NOW(a_div_rem, i_clk, i_rst_n, r_v[k] && !r_oct[k].zero,
            r_rem[k] < r_den[k], "partial remainder not below divisor")
    end

endmodule

### rtl/core/atan2_poly_approx.sv
`timescale 1ns / 1ps
`include "atan2_poly_approx_assert.svh"

// atan2_poly_approx: angle of a signed (x, y) vector in radians, signed with
// ANGLE_FRAC_BITS fraction bits (Q2.13 by default, pi = 25736), 16 bits wide so
// wider angle formats wrap. The ratio min/max is formed in Q0.16 by a 17-stage
// restoring divider, then a seventh-order odd polynomial is run by Horner's rule
// and folded out by octant. The zero vector gives 0, the negative x axis gives
// +pi. A transaction can be accepted on every clock unless an output stall holds
// the pipeline; it has 1 magnitude stage, 17 divider stages, one per quotient bit,
// and 7 polynomial and fold stages. Stalls on the output hold
// every busy stage while empty stages upstream keep filling.
module atan2_poly_approx
    import atan2pa_pkg::*;
#(
    parameter int IN_WIDTH        = IN_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [IN_WIDTH-1:0] i_x_coord,
    input  logic signed [IN_WIDTH-1:0] i_y_coord,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [ANGLE_W-1:0]  o_angle
);

    // pi and pi/2 rounded to nearest at the output scale, low bits kept
    localparam logic [ANGLE_W-1:0] PI_ANG =
        ANGLE_W'((PI_Q60 + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS));
    localparam logic [ANGLE_W-1:0] HALF_PI_ANG =
        ANGLE_W'((PI_Q60 + (64'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS));

    // rescale shifts from Q0.16 to the output format
    localparam int SH_R = (ANGLE_FRAC_BITS < 16) ? 16 - ANGLE_FRAC_BITS : 1;
    localparam int SH_L = (ANGLE_FRAC_BITS >= 16) ? ANGLE_FRAC_BITS - 16 : 0;

    // stages after the divider: square, three horner steps, final multiply,
    // rescale, octant fold
    localparam int PST = 7;

    // magnitude stage
    logic                r_s0_v;
    logic [IN_WIDTH-1:0] r_s0_mn;
    logic [IN_WIDTH-1:0] r_s0_mx;
    t_oct_flags          r_s0_oct;

    logic [IN_WIDTH-1:0] w_xu;
    logic [IN_WIDTH-1:0] w_yu;
    logic [IN_WIDTH-1:0] w_ax;
    logic [IN_WIDTH-1:0] w_ay;
    logic [IN_WIDTH-1:0] w_one;
    logic                w_s0_adv;
    t_oct_flags          w_in_oct;

    // divider handshake
    logic                w_div_ready;
    logic                w_div_valid;
    logic [QUO_W-1:0]    w_div_quo;
    t_oct_flags          w_div_oct;

    // polynomial pipeline control
    logic [PST-1:0]      r_pv;
    logic [PST-1:0]      w_padv;
    logic [PST-1:0]      w_pvin;

    // polynomial pipeline payload
    logic [16:0]         r_a_p1, r_a_p2, r_a_p3, r_a_p4;
    logic [16:0]         r_s_p1, r_s_p2, r_s_p3;
    logic [13:0]         r_t1_p2;
    logic [14:0]         r_t2_p3;
    logic [16:0]         r_t3_p4;
    logic [16:0]         r_r_p5;
    logic [ANGLE_W-1:0]  r_sc_p6;
    logic [ANGLE_W-1:0]  r_angle;
    t_oct_flags          r_oct_p1, r_oct_p2, r_oct_p3, r_oct_p4, r_oct_p5, r_oct_p6;

    logic [33:0]         w_sq;
    logic [28:0]         w_p2;
    logic [30:0]         w_p3;
    logic [31:0]         w_p4;
    logic [33:0]         w_p5;
    logic [13:0]         n_t1;
    logic [14:0]         n_t2;
    logic [16:0]         n_t3;
    logic [17:0]         w_rnd;
    logic [31:0]         w_lsh;
    logic [ANGLE_W-1:0]  n_sc;
    logic [ANGLE_W-1:0]  n_angle;

    // ---------------------------------------------------------------
    // magnitudes and octant flags
    // ---------------------------------------------------------------
    assign w_xu  = $unsigned(i_x_coord);
    assign w_yu  = $unsigned(i_y_coord);
    assign w_one = {{(IN_WIDTH-1){1'b0}}, 1'b1};
    // most negative input maps to 2^(IN_WIDTH-1), which fits unsigned
    assign w_ax  = w_xu[IN_WIDTH-1] ? (~w_xu + w_one) : w_xu;
    assign w_ay  = w_yu[IN_WIDTH-1] ? (~w_yu + w_one) : w_yu;

    always_comb begin
        w_in_oct.swap = w_ay > w_ax;
        w_in_oct.xneg = w_xu[IN_WIDTH-1];
        w_in_oct.yneg = w_yu[IN_WIDTH-1];
        w_in_oct.zero = (w_ax == '0) && (w_ay == '0);
    end

    assign w_s0_adv = !r_s0_v || w_div_ready;
    assign o_ready  = w_s0_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (w_s0_adv) begin
            r_s0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s0_adv) begin
            r_s0_mn  <= w_in_oct.swap ? w_ax : w_ay;
            r_s0_mx  <= w_in_oct.swap ? w_ay : w_ax;
            r_s0_oct <= w_in_oct;
        end
    end

    // ---------------------------------------------------------------
    // ratio min/max in Q0.16
    // ---------------------------------------------------------------
    atan2pa_div #(
        .NUM_W (IN_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s0_v),
        .o_ready (w_div_ready),
        .i_num   (r_s0_mn),
        .i_den   (r_s0_mx),
        .i_oct   (r_s0_oct),
        .o_valid (w_div_valid),
        .i_ready (w_padv[0]),
        .o_quo   (w_div_quo),
        .o_oct   (w_div_oct)
    );

    // ---------------------------------------------------------------
    // polynomial pipeline control, a stage moves when empty or draining
    // ---------------------------------------------------------------
    always_comb begin
        w_padv[PST-1] = !r_pv[PST-1] || i_ready;
        for (int k = PST - 2; k >= 0; k--) begin
            w_padv[k] = !r_pv[k] || w_padv[k+1];
        end
    end

    assign w_pvin = {r_pv[PST-2:0], w_div_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else begin
            for (int k = 0; k < PST; k++) begin
                if (w_padv[k]) begin
                    r_pv[k] <= w_pvin[k];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // datapath, at most one multiplier per stage
    // ---------------------------------------------------------------
    // s = a^2, at most 1.0
    assign w_sq = w_div_quo * w_div_quo;
    // t1 = C2 - C3*s
    assign w_p2 = COEF_C3 * r_s_p1;
    assign n_t1 = COEF_C2 - {1'b0, w_p2[28:16]};
    // t2 = C1 - s*t1
    assign w_p3 = r_s_p2 * r_t1_p2;
    assign n_t2 = COEF_C1 - w_p3[30:16];
    // t3 = 1 - s*t2
    assign w_p4 = r_s_p3 * r_t2_p3;
    assign n_t3 = Q16_ONE - {1'b0, w_p4[31:16]};
    // r = a*t3, first-octant angle in Q0.16
    assign w_p5 = r_a_p4 * r_t3_p4;

    // rescale: round half up when narrowing, exact shift when widening
    always_comb begin
        w_rnd = {1'b0, r_r_p5} + (18'd1 << (SH_R - 1));
        w_lsh = {15'd0, r_r_p5} << SH_L;
        if (ANGLE_FRAC_BITS < 16) begin
            n_sc = ANGLE_W'(w_rnd >> SH_R);
        end else begin
            n_sc = ANGLE_W'(w_lsh);
        end
    end

    // octant fold, all in modulo 2^16 so wrapped formats stay exact
    always_comb begin
        n_angle = r_sc_p6;
        if (r_oct_p6.swap) begin
            n_angle = HALF_PI_ANG - n_angle;
        end
        if (r_oct_p6.xneg) begin
            n_angle = PI_ANG - n_angle;
        end
        if (r_oct_p6.yneg) begin
            n_angle = ANGLE_W'(0) - n_angle;
        end
        if (r_oct_p6.zero) begin
            n_angle = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_padv[0]) begin
            r_a_p1   <= w_div_quo;
            r_s_p1   <= w_sq[32:16];
            r_oct_p1 <= w_div_oct;
        end
        if (w_padv[1]) begin
            r_a_p2   <= r_a_p1;
            r_s_p2   <= r_s_p1;
            r_t1_p2  <= n_t1;
            r_oct_p2 <= r_oct_p1;
        end
        if (w_padv[2]) begin
            r_a_p3   <= r_a_p2;
            r_s_p3   <= r_s_p2;
            r_t2_p3  <= n_t2;
            r_oct_p3 <= r_oct_p2;
        end
        if (w_padv[3]) begin
            r_a_p4   <= r_a_p3;
            r_t3_p4  <= n_t3;
            r_oct_p4 <= r_oct_p3;
        end
        if (w_padv[4]) begin
            r_r_p5   <= w_p5[32:16];
            r_oct_p5 <= r_oct_p4;
        end
        if (w_padv[5]) begin
            r_sc_p6  <= n_sc;
            r_oct_p6 <= r_oct_p5;
        end
        if (w_padv[6]) begin
            r_angle  <= n_angle;
        end
    end

    assign o_valid = r_pv[PST-1];
    assign o_angle = $signed(r_angle);

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `A2P_ASSERT_NEXT(a_top_enter, i_clk, i_rst_n, i_valid && o_ready, r_s0_v,
        "accepted transaction did not enter the magnitude stage")

    `A2P_ASSERT_NEXT(a_top_zero, i_clk, i_rst_n,
        r_pv[PST-2] && r_oct_p6.zero && w_padv[PST-1], o_angle == '0,
        "zero vector did not give a zero angle")

    `A2P_ASSERT_NOW(a_top_range, i_clk, i_rst_n,
        o_valid && (ANGLE_FRAC_BITS <= 13),
        (o_angle <= $signed(PI_ANG)) && (o_angle >= -$signed(PI_ANG)),
        "angle outside minus pi to pi")

endmodule
